FILE: rtl/core/afuas_pkg.sv
// Shared types, widths and scaling constants for the converter frame unpack,
// average and scale block. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package afuas_pkg;

	// Frame and sample geometry
	localparam int NUM_CH      = 8;
	localparam int CH_W        = $clog2(NUM_CH);
	localparam int RAW_W       = 18;
	localparam int OFS_W       = 10;
	localparam int SMP_W       = 19;
	localparam int AVG_W       = 20;
	localparam int CUR_W       = 14;
	localparam int FRAME_W     = 144;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 128;
	localparam int CFG_IDX_W   = 4;
	localparam int DEPTH_DEF   = 16;

	// Offset register reset values, channel 0 first
	localparam logic [OFS_W-1:0] OFS_RESET [NUM_CH] = '{
		10'h3F6, 10'h3F6, 10'h006, 10'h001, 10'h3FB, 10'h3FB, 10'h3F9, 10'h3FA
	};

	// Current scaling: Q16 gain and bias, then saturation
	localparam int CURX_W   = 32;
	localparam int CUR_MUL  = 2500;
	localparam int CUR_BIAS = 98304;
	localparam int CUR_SH   = 16;
	localparam int CUR_MIN  = -5020;
	localparam int CUR_MAX  = 5022;

	// Engineering values: working width, gain, bias, shift, limits
	localparam int WAT_X   = 19;
	localparam int WAT_W   = 15;
	localparam int WAT_K   = 25;
	localparam int WAT_C   = 9992;
	localparam int WAT_SH  = 4;
	localparam int WAT_MIN = -8466;
	localparam int WAT_MAX = 7220;

	localparam int AIR_X   = 21;
	localparam int AIR_W   = 20;
	localparam int AIR_K   = 125;
	localparam int AIR_C   = 49999;
	localparam int AIR_SH  = 1;
	localparam int AIR_MIN = -338625;
	localparam int AIR_MAX = 288813;

	localparam int PRS_X   = 18;
	localparam int PRS_W   = 16;
	localparam int PRS_K   = 15;
	localparam int PRS_C   = 5998;
	localparam int PRS_SH  = 2;
	localparam int PRS_MIN = -20318;
	localparam int PRS_MAX = 17330;

	localparam int TMP_X   = 33;
	localparam int TMP_W   = 17;
	localparam int TMP_K   = 520094;
	localparam int TMP_C   = 301583565;
	localparam int TMP_SH  = 16;
	localparam int TMP_MIN = -44426;
	localparam int TMP_MAX = 35246;

	// Stage enables from the sequencer to the lanes and the merge stage
	typedef struct packed {
		logic acc;
		logic mag;
		logic mul;
		logic corr;
		logic sgn;
		logic cur1;
		logic cur2;
		logic eng1;
		logic eng2;
	} ctl_t;

endpackage

FILE: rtl/core/afuas_lane.sv
// One channel lane: offset add, moving-average history and running sum,
// rounded mean by reciprocal multiply, Q16 current scaling. Uses afuas_pkg.
`timescale 1ns / 1ps

module afuas_lane #(
	parameter int DEPTH = afuas_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  afuas_pkg::ctl_t                     ctl,
	input  logic [$clog2(DEPTH)-1:0]            slot,
	input  logic                                wrapped,
	input  logic [afuas_pkg::RAW_W-1:0]         raw,
	input  logic [afuas_pkg::OFS_W-1:0]         offset,
	output logic signed [afuas_pkg::CUR_W-1:0]  cur
);

	localparam int SMP_W  = afuas_pkg::SMP_W;
	localparam int AVG_W  = afuas_pkg::AVG_W;
	localparam int CUR_W  = afuas_pkg::CUR_W;
	localparam int CURX_W = afuas_pkg::CURX_W;
	localparam int CUR_SH = afuas_pkg::CUR_SH;
	localparam int SUM_W  = SMP_W + $clog2(DEPTH) + 1;
	localparam int N_W    = SUM_W + 2;
	localparam int DIV    = 2 * DEPTH;
	localparam int Q_W    = N_W - $clog2(DIV) + 1;
	localparam longint unsigned RECIP = (64'd1 << N_W) / DIV;
	localparam logic [Q_W-1:0] RECIP_C = Q_W'(RECIP);
	localparam int Y_W    = CURX_W - CUR_SH;

	logic signed [SMP_W-1:0]  hist_mem [DEPTH];
	logic signed [SMP_W-1:0]  rd_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic signed [SMP_W-1:0]  smp;
	logic signed [SMP_W-1:0]  old_smp;
	logic signed [SUM_W:0]    sum_ext;
	logic signed [N_W-1:0]    num;
	logic [Q_W-1:0]           quo0;
	logic [N_W-1:0]           rem;
	logic signed [CURX_W-1:0] x_rnd;
	logic signed [Y_W-1:0]    y_cur;

	logic [N_W-1:0]           mag_s2, mag_s3;
	logic                     neg_s2, neg_s3, neg_s4;
	logic [N_W+Q_W-1:0]       prod_s3;
	logic [Q_W-1:0]           quo_s4;
	logic signed [AVG_W-1:0]  avg_s5;
	logic signed [CURX_W-1:0] x_s6;
	logic signed [CUR_W-1:0]  cur_s7;

	// Offset-corrected sample; history slots not yet written read as zero
	assign smp     = SMP_W'($signed(raw)) + SMP_W'($signed(offset));
	assign old_smp = wrapped ? rd_q : '0;
	assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(smp) - (SUM_W+1)'(old_smp);

	// History memory: one write, one registered read at the current slot
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			hist_mem[slot] <= smp;
		end
		rd_q <= hist_mem[slot];
	end

	// Running sum of the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_ext[SUM_W-1:0];
		end
	end

	// Rounded mean: magnitude, reciprocal multiply, one-step correction, sign
	assign num  = (N_W'(sum_q) <<< 1) + N_W'(DEPTH);
	assign quo0 = prod_s3[N_W +: Q_W];
	assign rem  = mag_s3 - N_W'(quo0) * N_W'(DIV);

	always_ff @(posedge clk) begin
		if (ctl.mag) begin
			mag_s2 <= num[N_W-1] ? N_W'(-num) : N_W'(num);
			neg_s2 <= num[N_W-1];
		end
		if (ctl.mul) begin
			prod_s3 <= (N_W+Q_W)'(mag_s2) * (N_W+Q_W)'(RECIP_C);
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
		end
		if (ctl.corr) begin
			quo_s4 <= quo0 + Q_W'(rem >= N_W'(DIV));
			neg_s4 <= neg_s3;
		end
		if (ctl.sgn) begin
			avg_s5 <= neg_s4 ? -AVG_W'(quo_s4) : AVG_W'(quo_s4);
		end
	end

	// Current: Q16 gain and bias, truncate toward zero, saturate
	assign x_rnd = x_s6 + (x_s6[CURX_W-1] ? CURX_W'((1 << CUR_SH) - 1) : CURX_W'(0));
	assign y_cur = $signed(x_rnd[CURX_W-1:CUR_SH]);

	always_ff @(posedge clk) begin
		if (ctl.cur1) begin
			x_s6 <= CURX_W'(avg_s5) * CURX_W'(afuas_pkg::CUR_MUL)
				+ CURX_W'(afuas_pkg::CUR_BIAS);
		end
		if (ctl.cur2) begin
			if (y_cur < Y_W'(afuas_pkg::CUR_MIN)) begin
				cur_s7 <= CUR_W'(afuas_pkg::CUR_MIN);
			end else if (y_cur > Y_W'(afuas_pkg::CUR_MAX)) begin
				cur_s7 <= CUR_W'(afuas_pkg::CUR_MAX);
			end else begin
				cur_s7 <= y_cur[CUR_W-1:0];
			end
		end
	end

	assign cur = cur_s7;

endmodule

FILE: rtl/core/afuas_merge.sv
// Merge stage: turns lane currents into water flow, air flow, air pressure
// and the two temperatures, with saturation. Uses afuas_pkg.
`timescale 1ns / 1ps

module afuas_merge (
	input  logic                                clk,
	input  afuas_pkg::ctl_t                     ctl,
	input  logic signed [afuas_pkg::CUR_W-1:0]  cur [afuas_pkg::NUM_CH],
	output logic signed [afuas_pkg::WAT_W-1:0]  water_flow,
	output logic signed [afuas_pkg::AIR_W-1:0]  air_flow,
	output logic signed [afuas_pkg::PRS_W-1:0]  air_pressure,
	output logic signed [afuas_pkg::TMP_W-1:0]  inlet_temp,
	output logic signed [afuas_pkg::TMP_W-1:0]  outlet_temp
);

	localparam int WAT_X = afuas_pkg::WAT_X;
	localparam int AIR_X = afuas_pkg::AIR_X;
	localparam int PRS_X = afuas_pkg::PRS_X;
	localparam int TMP_X = afuas_pkg::TMP_X;
	localparam int WAT_W = afuas_pkg::WAT_W;
	localparam int AIR_W = afuas_pkg::AIR_W;
	localparam int PRS_W = afuas_pkg::PRS_W;
	localparam int TMP_W = afuas_pkg::TMP_W;
	localparam int WAT_SH = afuas_pkg::WAT_SH;
	localparam int AIR_SH = afuas_pkg::AIR_SH;
	localparam int PRS_SH = afuas_pkg::PRS_SH;
	localparam int TMP_SH = afuas_pkg::TMP_SH;

	logic signed [WAT_X-1:0] wat_s8, wat_s9, wat_rnd;
	logic signed [AIR_X-1:0] air_s8, air_s9, air_rnd;
	logic signed [PRS_X-1:0] prs_s8, prs_s9, prs_rnd;
	logic signed [TMP_X-1:0] tin_s8, tin_s9, tin_rnd;
	logic signed [TMP_X-1:0] tout_s8, tout_s9, tout_rnd;
	logic signed [WAT_W-1:0] wat_y;
	logic signed [AIR_W-1:0] air_y;
	logic signed [PRS_W-1:0] prs_y;
	logic signed [TMP_W-1:0] tin_y, tout_y;

	// Gain, then bias
	always_ff @(posedge clk) begin
		if (ctl.eng1) begin
			wat_s8  <= WAT_X'(cur[0]) * WAT_X'(afuas_pkg::WAT_K);
			air_s8  <= AIR_X'(cur[1]) * AIR_X'(afuas_pkg::AIR_K);
			prs_s8  <= PRS_X'(cur[3]) * PRS_X'(afuas_pkg::PRS_K);
			tin_s8  <= TMP_X'(cur[5]) * TMP_X'(afuas_pkg::TMP_K);
			tout_s8 <= TMP_X'(cur[4]) * TMP_X'(afuas_pkg::TMP_K);
		end
		if (ctl.eng2) begin
			wat_s9  <= wat_s8 - WAT_X'(afuas_pkg::WAT_C);
			air_s9  <= air_s8 - AIR_X'(afuas_pkg::AIR_C);
			prs_s9  <= prs_s8 - PRS_X'(afuas_pkg::PRS_C);
			tin_s9  <= tin_s8 - TMP_X'(afuas_pkg::TMP_C);
			tout_s9 <= tout_s8 - TMP_X'(afuas_pkg::TMP_C);
		end
	end

	// Divide by a power of two with truncation toward zero
	assign wat_rnd  = wat_s9 + (wat_s9[WAT_X-1] ? WAT_X'((1 << WAT_SH) - 1) : WAT_X'(0));
	assign air_rnd  = air_s9 + (air_s9[AIR_X-1] ? AIR_X'((1 << AIR_SH) - 1) : AIR_X'(0));
	assign prs_rnd  = prs_s9 + (prs_s9[PRS_X-1] ? PRS_X'((1 << PRS_SH) - 1) : PRS_X'(0));
	assign tin_rnd  = tin_s9 + (tin_s9[TMP_X-1] ? TMP_X'((1 << TMP_SH) - 1) : TMP_X'(0));
	assign tout_rnd = tout_s9 + (tout_s9[TMP_X-1] ? TMP_X'((1 << TMP_SH) - 1) : TMP_X'(0));

	assign wat_y  = $signed(wat_rnd[WAT_X-1:WAT_SH]);
	assign air_y  = $signed(air_rnd[AIR_X-1:AIR_SH]);
	assign prs_y  = $signed(prs_rnd[PRS_X-1:PRS_SH]);
	assign tin_y  = $signed(tin_rnd[TMP_X-1:TMP_SH]);
	assign tout_y = $signed(tout_rnd[TMP_X-1:TMP_SH]);

	// Saturate to the stated ranges
	always_comb begin
		water_flow = wat_y;
		if (wat_y < WAT_W'(afuas_pkg::WAT_MIN)) water_flow = WAT_W'(afuas_pkg::WAT_MIN);
		if (wat_y > WAT_W'(afuas_pkg::WAT_MAX)) water_flow = WAT_W'(afuas_pkg::WAT_MAX);

		air_flow = air_y;
		if (air_y < AIR_W'(afuas_pkg::AIR_MIN)) air_flow = AIR_W'(afuas_pkg::AIR_MIN);
		if (air_y > AIR_W'(afuas_pkg::AIR_MAX)) air_flow = AIR_W'(afuas_pkg::AIR_MAX);

		air_pressure = prs_y;
		if (prs_y < PRS_W'(afuas_pkg::PRS_MIN)) air_pressure = PRS_W'(afuas_pkg::PRS_MIN);
		if (prs_y > PRS_W'(afuas_pkg::PRS_MAX)) air_pressure = PRS_W'(afuas_pkg::PRS_MAX);

		inlet_temp = tin_y;
		if (tin_y < TMP_W'(afuas_pkg::TMP_MIN)) inlet_temp = TMP_W'(afuas_pkg::TMP_MIN);
		if (tin_y > TMP_W'(afuas_pkg::TMP_MAX)) inlet_temp = TMP_W'(afuas_pkg::TMP_MAX);

		outlet_temp = tout_y;
		if (tout_y < TMP_W'(afuas_pkg::TMP_MIN)) outlet_temp = TMP_W'(afuas_pkg::TMP_MIN);
		if (tout_y > TMP_W'(afuas_pkg::TMP_MAX)) outlet_temp = TMP_W'(afuas_pkg::TMP_MAX);
	end

endmodule

FILE: rtl/core/adc_frame_unpack_average_scale_top.sv
// Top level: stream ports, offset registers, frame capture, stage sequencer,
// eight afuas_lane instances, afuas_merge and the result register. Uses afuas_pkg.
`timescale 1ns / 1ps

// Takes one 18-byte frame of eight 18-bit converter samples per input beat
// and returns one result beat per frame. Each frame is held while a stage
// sequencer steps it through the eight channel lanes (sum update, rounded
// mean by reciprocal multiply and correction, Q16 current) and then the
// merge stage into the result register; the next frame is taken only once
// the sequencer is back in its idle step, so a frame is never accepted
// before the previous one is through. A stalled result stays in the
// output register and holds the sequencer in its last step. The history
// memories need no clearing pass: until DEPTH frames have arrived, slots not
// yet written count as zero. Offset registers may be written at any time the
// block is idle; writes to an index above 7 are ignored.
module adc_frame_unpack_average_scale_top #(
	parameter int DEPTH = afuas_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [afuas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [afuas_pkg::OFS_W-1:0]           cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// frame_bytes_0_5 [47:0], frame_bytes_6_11 [95:48], frame_bytes_12_17 [143:96]
	input  logic [afuas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// water_flow [14:0], air_flow [34:15], air_pressure [50:35], inlet_temp [67:51],
	// outlet_temp [84:68], current_ch2 [98:85], current_ch6 [112:99],
	// current_ch7 [126:113], zero [127]
	output logic [afuas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int NUM_CH = afuas_pkg::NUM_CH;
	localparam int RAW_W  = afuas_pkg::RAW_W;
	localparam int OFS_W  = afuas_pkg::OFS_W;
	localparam int CUR_W  = afuas_pkg::CUR_W;
	localparam int SLOT_W = $clog2(DEPTH);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ACC  = 11'b000_0000_0010,
		ST_MAG  = 11'b000_0000_0100,
		ST_MUL  = 11'b000_0000_1000,
		ST_CORR = 11'b000_0001_0000,
		ST_SGN  = 11'b000_0010_0000,
		ST_CUR1 = 11'b000_0100_0000,
		ST_CUR2 = 11'b000_1000_0000,
		ST_ENG1 = 11'b001_0000_0000,
		ST_ENG2 = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	state_t                              state_q, state_nxt;
	afuas_pkg::ctl_t                     ctl;
	logic [OFS_W-1:0]                    offset_q [NUM_CH];
	logic [afuas_pkg::FRAME_W-1:0]       frame_q;
	logic [SLOT_W-1:0]                   slot_q;
	logic                                wrapped_q;
	logic                                m_valid_q;
	logic [afuas_pkg::OUT_TDATA_W-1:0]   m_data_q;
	logic signed [CUR_W-1:0]             cur [NUM_CH];
	logic signed [afuas_pkg::WAT_W-1:0]  water_flow;
	logic signed [afuas_pkg::AIR_W-1:0]  air_flow;
	logic signed [afuas_pkg::PRS_W-1:0]  air_pressure;
	logic signed [afuas_pkg::TMP_W-1:0]  inlet_temp;
	logic signed [afuas_pkg::TMP_W-1:0]  outlet_temp;
	logic                                in_beat;
	logic                                out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				offset_q[i] <= afuas_pkg::OFS_RESET[i];
			end
		end else if (cfg_we && cfg_index < afuas_pkg::CFG_IDX_W'(NUM_CH)) begin
			offset_q[cfg_index[afuas_pkg::CH_W-1:0]] <= cfg_data;
		end
	end

	// Capture the frame with byte 0 at the top; channel c sits at bits 18c up
	always_ff @(posedge clk) begin
		if (in_beat) begin
			frame_q <= {s_axis_tdata[47:0], s_axis_tdata[95:48], s_axis_tdata[143:96]};
		end
	end

	// Sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_nxt = ST_ACC;
			ST_ACC:  state_nxt = ST_MAG;
			ST_MAG:  state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_CORR;
			ST_CORR: state_nxt = ST_SGN;
			ST_SGN:  state_nxt = ST_CUR1;
			ST_CUR1: state_nxt = ST_CUR2;
			ST_CUR2: state_nxt = ST_ENG1;
			ST_ENG1: state_nxt = ST_ENG2;
			ST_ENG2: state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign ctl.acc  = (state_q == ST_ACC);
	assign ctl.mag  = (state_q == ST_MAG);
	assign ctl.mul  = (state_q == ST_MUL);
	assign ctl.corr = (state_q == ST_CORR);
	assign ctl.sgn  = (state_q == ST_SGN);
	assign ctl.cur1 = (state_q == ST_CUR1);
	assign ctl.cur2 = (state_q == ST_CUR2);
	assign ctl.eng1 = (state_q == ST_ENG1);
	assign ctl.eng2 = (state_q == ST_ENG2);

	// Advance the history slot once per frame; mark the first wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (ctl.acc) begin
			if (slot_q == SLOT_W'(DEPTH - 1)) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	// Channel lanes
	for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
		afuas_lane #(
			.DEPTH (DEPTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.slot    (slot_q),
			.wrapped (wrapped_q),
			.raw     (frame_q[RAW_W*g +: RAW_W]),
			.offset  (offset_q[g]),
			.cur     (cur[g])
		);
	end

	afuas_merge u_merge (
		.clk          (clk),
		.ctl          (ctl),
		.cur          (cur),
		.water_flow   (water_flow),
		.air_flow     (air_flow),
		.air_pressure (air_pressure),
		.inlet_temp   (inlet_temp),
		.outlet_temp  (outlet_temp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {1'b0, cur[7], cur[6], cur[2], outlet_temp, inlet_temp,
				air_pressure, air_flow, water_flow};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// A taken frame starts its sum update in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_ACC))
	else $error("accepted frame did not enter the accumulate step");

	// The write slot stays inside the history depth
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(DEPTH - 1))
	else $error("history slot beyond depth");

	// Once the history has wrapped it stays fully populated
	assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
	else $error("history wrap mark cleared");

	// A stalled result holds the sequencer in its last step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_valid_q && !m_axis_tready) |=> (state_q == ST_OUT))
	else $error("result register overwritten while stalled");

endmodule
